// ----- design/kerm_pkg.sv -----
// ----------------------------------------------------------------------------
// kerm_pkg: shared types and constants for the key event remapper
// Key code and action encodings, the remap plan that one input event turns
// into, and the sizing of the queue between the front and back ends.
// ----------------------------------------------------------------------------
package kerm_pkg;

  // Width of a key code.
  localparam int KEY_BITS = 10;

  // Key actions.
  localparam logic [1:0] ACT_RELEASE    = 2'd0;
  localparam logic [1:0] ACT_PRESS      = 2'd1;
  localparam logic [1:0] ACT_REPEAT     = 2'd2;
  // Raw action code three, which is taken as autorepeat.
  localparam logic [1:0] ACT_REPEAT_ALT = 2'd3;

  // Key events of one plan, not counting the closing sync.
  localparam int PLAN_KEYS = 3;
  localparam int PLAN_CNT_BITS = $clog2(PLAN_KEYS + 1);

  // Queue between front and back end (a power of two).
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

  // Key codes.
  localparam logic [KEY_BITS-1:0] K_3      = KEY_BITS'(4);
  localparam logic [KEY_BITS-1:0] K_TAB    = KEY_BITS'(15);
  localparam logic [KEY_BITS-1:0] K_W      = KEY_BITS'(17);
  localparam logic [KEY_BITS-1:0] K_U      = KEY_BITS'(22);
  localparam logic [KEY_BITS-1:0] K_I      = KEY_BITS'(23);
  localparam logic [KEY_BITS-1:0] K_LCTRL  = KEY_BITS'(29);
  localparam logic [KEY_BITS-1:0] K_A      = KEY_BITS'(30);
  localparam logic [KEY_BITS-1:0] K_S      = KEY_BITS'(31);
  localparam logic [KEY_BITS-1:0] K_D      = KEY_BITS'(32);
  localparam logic [KEY_BITS-1:0] K_F      = KEY_BITS'(33);
  localparam logic [KEY_BITS-1:0] K_H      = KEY_BITS'(35);
  localparam logic [KEY_BITS-1:0] K_J      = KEY_BITS'(36);
  localparam logic [KEY_BITS-1:0] K_K      = KEY_BITS'(37);
  localparam logic [KEY_BITS-1:0] K_L      = KEY_BITS'(38);
  localparam logic [KEY_BITS-1:0] K_LSHIFT = KEY_BITS'(42);
  localparam logic [KEY_BITS-1:0] K_Z      = KEY_BITS'(44);
  localparam logic [KEY_BITS-1:0] K_X      = KEY_BITS'(45);
  localparam logic [KEY_BITS-1:0] K_C      = KEY_BITS'(46);
  localparam logic [KEY_BITS-1:0] K_N      = KEY_BITS'(49);
  localparam logic [KEY_BITS-1:0] K_LALT   = KEY_BITS'(56);
  localparam logic [KEY_BITS-1:0] K_CAPS   = KEY_BITS'(58);
  localparam logic [KEY_BITS-1:0] K_HOME   = KEY_BITS'(102);
  localparam logic [KEY_BITS-1:0] K_UP     = KEY_BITS'(103);
  localparam logic [KEY_BITS-1:0] K_PGUP   = KEY_BITS'(104);
  localparam logic [KEY_BITS-1:0] K_LEFT   = KEY_BITS'(105);
  localparam logic [KEY_BITS-1:0] K_RIGHT  = KEY_BITS'(106);
  localparam logic [KEY_BITS-1:0] K_END    = KEY_BITS'(107);
  localparam logic [KEY_BITS-1:0] K_DOWN   = KEY_BITS'(108);
  localparam logic [KEY_BITS-1:0] K_PGDN   = KEY_BITS'(109);
  localparam logic [KEY_BITS-1:0] K_LMETA  = KEY_BITS'(125);

  // Key events that one input event expands into, in emission order.
  typedef struct packed {
    logic [PLAN_CNT_BITS-1:0]           cnt;
    logic [PLAN_KEYS-1:0][KEY_BITS-1:0] code;
    logic [PLAN_KEYS-1:0][1:0]          act;
  } plan_t;

endpackage

// ----- design/key_event_remapper.sv -----
// ----------------------------------------------------------------------------
// key_event_remapper: keyboard key event remapper
// Remaps key events through capslock, meta and ctrl layers with modifier
// chords, and closes the results of every event with a sync result.
// ----------------------------------------------------------------------------
// Each accepted key event yields one to four results: up to three key events
// followed by a sync result with last set, delivered one per cycle from the
// output register while each waiting result is popped. A new event is taken
// in every cycle while the two-entry plan queue between the classifier and
// the emitter has room, so the sustained rate is set by the emitter, which
// sends one result for a swallowed key, two for a plain key and four for the
// press or release of a two-modifier chord. The first result of an event
// passes through the plan queue and then the output register.
module key_event_remapper (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [kerm_pkg::KEY_BITS-1:0] in_key_code,
  input  logic [1:0]                    in_key_action,
  output logic                          empty,
  input  logic                          pop,
  output logic [kerm_pkg::KEY_BITS-1:0] out_code,
  output logic [1:0]                    out_action,
  output logic                          out_is_sync,
  output logic                          out_last
);

  logic            accept;
  kerm_pkg::plan_t front_plan;
  logic            q_valid;
  logic            q_rd;
  kerm_pkg::plan_t q_head;

  // An input transaction completes when push meets a queue with room.
  assign accept = push && !full;

  kerm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .key_code   (in_key_code),
    .key_action (in_key_action),
    .plan       (front_plan)
  );

  kerm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_plan (front_plan),
    .full    (full),
    .valid   (q_valid),
    .head    (q_head),
    .rd_en   (q_rd)
  );

  kerm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_rd        (q_rd),
    .empty       (empty),
    .pop         (pop),
    .out_code    (out_code),
    .out_action  (out_action),
    .out_is_sync (out_is_sync),
    .out_last    (out_last)
  );

endmodule

// ----- design/kerm_front.sv -----
// ----------------------------------------------------------------------------
// kerm_front: event classification and modifier tracking
// Accepts one key event per cycle while the queue has room, updates the
// held-modifier and capslock state, and plans up to three key events.
// ----------------------------------------------------------------------------
module kerm_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [kerm_pkg::KEY_BITS-1:0] key_code,
  input  logic [1:0]                    key_action,
  output kerm_pkg::plan_t               plan
);

  // Modifier and layer state.
  logic [1:0]                    alt_held_r, alt_held_nxt;
  logic [1:0]                    ctrl_held_r, ctrl_held_nxt;
  logic [1:0]                    meta_held_r, meta_held_nxt;
  logic                          caps_layer_r, caps_layer_nxt;
  logic                          caps_sticky_r, caps_sticky_nxt;
  logic [kerm_pkg::KEY_BITS-1:0] prior_key_r;

  logic [1:0] act;
  logic       plain_mods;

  // One key event sent on as it is.
  function automatic kerm_pkg::plan_t single(input logic [kerm_pkg::KEY_BITS-1:0] c,
                                             input logic [1:0] a);
    kerm_pkg::plan_t p;
    p = '0;
    p.cnt = kerm_pkg::PLAN_CNT_BITS'(1);
    p.code[0] = c;
    p.act[0] = a;
    return p;
  endfunction

  // A key with one or two modifiers: press leads with the modifiers, release
  // trails them in the same order, and a repeat carries only the key.
  function automatic kerm_pkg::plan_t chord(input logic [kerm_pkg::KEY_BITS-1:0] m1,
                                            input logic [kerm_pkg::KEY_BITS-1:0] m2,
                                            input logic two,
                                            input logic [kerm_pkg::KEY_BITS-1:0] c,
                                            input logic [1:0] a);
    kerm_pkg::plan_t p;
    p = '0;
    priority if (a == kerm_pkg::ACT_PRESS) begin
      p.code[0] = m1;
      p.act[0] = kerm_pkg::ACT_PRESS;
      p.act[1] = kerm_pkg::ACT_PRESS;
      p.act[2] = kerm_pkg::ACT_PRESS;
      if (two) begin
        p.code[1] = m2;
        p.code[2] = c;
        p.cnt = kerm_pkg::PLAN_CNT_BITS'(3);
      end else begin
        p.code[1] = c;
        p.cnt = kerm_pkg::PLAN_CNT_BITS'(2);
      end
    end else if (a == kerm_pkg::ACT_REPEAT) begin
      p.code[0] = c;
      p.act[0] = kerm_pkg::ACT_REPEAT;
      p.cnt = kerm_pkg::PLAN_CNT_BITS'(1);
    end else begin
      p.code[0] = c;
      p.code[1] = m1;
      p.code[2] = m2;
      p.act[0] = kerm_pkg::ACT_RELEASE;
      p.act[1] = kerm_pkg::ACT_RELEASE;
      p.act[2] = kerm_pkg::ACT_RELEASE;
      p.cnt = two ? kerm_pkg::PLAN_CNT_BITS'(3) : kerm_pkg::PLAN_CNT_BITS'(2);
    end
    return p;
  endfunction

  // Action code three behaves as autorepeat.
  assign act = (key_action == kerm_pkg::ACT_REPEAT_ALT) ? kerm_pkg::ACT_REPEAT : key_action;
  assign plain_mods = (ctrl_held_r == 2'd0) && (alt_held_r == 2'd0) &&
                      (meta_held_r == 2'd0);

  // Classification and next state.
  always_comb begin
    alt_held_nxt    = alt_held_r;
    ctrl_held_nxt   = ctrl_held_r;
    meta_held_nxt   = meta_held_r;
    caps_layer_nxt  = caps_layer_r;
    caps_sticky_nxt = caps_sticky_r;
    plan            = single(key_code, act);
    priority if (key_code == kerm_pkg::K_LALT) begin
      alt_held_nxt = act;
      plan = single(kerm_pkg::K_LCTRL, act);
    end else if (key_code == kerm_pkg::K_LCTRL) begin
      ctrl_held_nxt = act;
      plan = '0;
    end else if (key_code == kerm_pkg::K_CAPS) begin
      plan = '0;
      if (act == kerm_pkg::ACT_PRESS) begin
        caps_layer_nxt = 1'b1;
      end else if (act == kerm_pkg::ACT_RELEASE) begin
        // A tap flips the sticky layer; a release after another key drops it.
        if (prior_key_r == kerm_pkg::K_CAPS) begin
          caps_sticky_nxt = ~caps_sticky_r;
          caps_layer_nxt  = ~caps_sticky_r;
        end else begin
          caps_sticky_nxt = 1'b0;
          caps_layer_nxt  = 1'b0;
        end
      end
    end else if (key_code == kerm_pkg::K_LMETA) begin
      meta_held_nxt = act;
      plan = '0;
      if (prior_key_r == kerm_pkg::K_LMETA && act == kerm_pkg::ACT_RELEASE) begin
        plan.cnt = kerm_pkg::PLAN_CNT_BITS'(2);
        plan.code[0] = kerm_pkg::K_LMETA;
        plan.act[0] = kerm_pkg::ACT_PRESS;
        plan.code[1] = kerm_pkg::K_LMETA;
        plan.act[1] = kerm_pkg::ACT_RELEASE;
      end
    end else if (caps_layer_r && plain_mods) begin
      // Capslock navigation layer.
      unique case (key_code)
        kerm_pkg::K_I: plan = single(kerm_pkg::K_UP, act);
        kerm_pkg::K_J: plan = single(kerm_pkg::K_LEFT, act);
        kerm_pkg::K_K: plan = single(kerm_pkg::K_DOWN, act);
        kerm_pkg::K_L: plan = single(kerm_pkg::K_RIGHT, act);
        kerm_pkg::K_U: plan = single(kerm_pkg::K_PGUP, act);
        kerm_pkg::K_N: plan = single(kerm_pkg::K_PGDN, act);
        kerm_pkg::K_A: plan = single(kerm_pkg::K_HOME, act);
        kerm_pkg::K_D: plan = single(kerm_pkg::K_END, act);
        kerm_pkg::K_W: plan = chord(kerm_pkg::K_LCTRL, '0, 1'b0, kerm_pkg::K_HOME, act);
        kerm_pkg::K_S: plan = chord(kerm_pkg::K_LCTRL, '0, 1'b0, kerm_pkg::K_END, act);
        kerm_pkg::K_H: plan = chord(kerm_pkg::K_LCTRL, '0, 1'b0, kerm_pkg::K_LEFT, act);
        kerm_pkg::K_F: plan = chord(kerm_pkg::K_LCTRL, '0, 1'b0, kerm_pkg::K_RIGHT, act);
        kerm_pkg::K_3: plan = single(kerm_pkg::K_A, act);
        default:       plan = single(key_code, act);
      endcase
    end else if (ctrl_held_r != 2'd0 && meta_held_r != 2'd0 &&
                 key_code == kerm_pkg::K_L) begin
      plan = chord(kerm_pkg::K_LMETA, '0, 1'b0, kerm_pkg::K_L, act);
    end else if (meta_held_r != 2'd0) begin
      // Meta layer: tab switching and window keys.
      unique case (key_code)
        kerm_pkg::K_J, kerm_pkg::K_LEFT:
          plan = chord(kerm_pkg::K_LCTRL, kerm_pkg::K_LSHIFT, 1'b1, kerm_pkg::K_TAB, act);
        kerm_pkg::K_L, kerm_pkg::K_RIGHT:
          plan = chord(kerm_pkg::K_LCTRL, '0, 1'b0, kerm_pkg::K_TAB, act);
        kerm_pkg::K_I, kerm_pkg::K_UP:
          plan = chord(kerm_pkg::K_LMETA, '0, 1'b0, kerm_pkg::K_UP, act);
        kerm_pkg::K_K, kerm_pkg::K_DOWN:
          plan = chord(kerm_pkg::K_LMETA, '0, 1'b0, kerm_pkg::K_DOWN, act);
        kerm_pkg::K_F:
          plan = chord(kerm_pkg::K_LMETA, '0, 1'b0, kerm_pkg::K_F, act);
        default:
          plan = single(key_code, act);
      endcase
    end else if (ctrl_held_r != 2'd0) begin
      // Ctrl layer: editing chords.
      unique case (key_code)
        kerm_pkg::K_C:
          plan = chord(kerm_pkg::K_LCTRL, kerm_pkg::K_LSHIFT, 1'b1, kerm_pkg::K_C, act);
        kerm_pkg::K_L, kerm_pkg::K_D, kerm_pkg::K_X, kerm_pkg::K_K, kerm_pkg::K_U,
        kerm_pkg::K_Z:
          plan = chord(kerm_pkg::K_LCTRL, '0, 1'b0, key_code, act);
        default:
          plan = single(key_code, act);
      endcase
    end
  end

  // State registers, updated on each accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alt_held_r    <= 2'd0;
      ctrl_held_r   <= 2'd0;
      meta_held_r   <= 2'd0;
      caps_layer_r  <= 1'b0;
      caps_sticky_r <= 1'b0;
      prior_key_r   <= '0;
    end else if (accept) begin
      alt_held_r    <= alt_held_nxt;
      ctrl_held_r   <= ctrl_held_nxt;
      meta_held_r   <= meta_held_nxt;
      caps_layer_r  <= caps_layer_nxt;
      caps_sticky_r <= caps_sticky_nxt;
      prior_key_r   <= key_code;
    end
  end

endmodule

// ----- design/kerm_queue.sv -----
// ----------------------------------------------------------------------------
// kerm_queue: plan queue between front and back end
// A short register queue that lets the classifier run ahead of the emitter.
// ----------------------------------------------------------------------------
module kerm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  kerm_pkg::plan_t wr_plan,
  output logic            full,
  output logic            valid,
  output kerm_pkg::plan_t head,
  input  logic            rd_en
);

  kerm_pkg::plan_t                    slot_r [kerm_pkg::QUEUE_DEPTH];
  logic [kerm_pkg::QPTR_BITS-1:0]     wr_ptr_r;
  logic [kerm_pkg::QPTR_BITS-1:0]     rd_ptr_r;
  logic [kerm_pkg::QPTR_BITS:0]       cnt_r, cnt_nxt;

  assign full  = (cnt_r == (kerm_pkg::QPTR_BITS + 1)'(kerm_pkg::QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = slot_r[rd_ptr_r];

  // Occupancy follows writes and reads.
  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_plan;
    end
  end

endmodule

// ----- design/kerm_back.sv -----
// ----------------------------------------------------------------------------
// kerm_back: result emitter
// Walks the queue's head plan one key event per cycle while output is free,
// closes it with a sync result, and holds each result in an output register.
// ----------------------------------------------------------------------------
module kerm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  kerm_pkg::plan_t               q_head,
  output logic                          q_rd,
  output logic                          empty,
  input  logic                          pop,
  output logic [kerm_pkg::KEY_BITS-1:0] out_code,
  output logic [1:0]                    out_action,
  output logic                          out_is_sync,
  output logic                          out_last
);

  logic [kerm_pkg::PLAN_CNT_BITS-1:0] idx_r, idx_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               load;
  logic                               at_sync;
  logic [kerm_pkg::KEY_BITS-1:0]      sel_code;
  logic [1:0]                         sel_act;

  assign empty   = !out_valid_r;
  assign load    = q_valid && (!out_valid_r || pop);
  assign at_sync = (idx_r == q_head.cnt);
  assign q_rd    = load && at_sync;

  // Pick the current key event of the plan; the sync carries zeros.
  always_comb begin
    sel_code = '0;
    sel_act  = kerm_pkg::ACT_RELEASE;
    if (!at_sync) begin
      unique case (idx_r)
        kerm_pkg::PLAN_CNT_BITS'(0): begin
          sel_code = q_head.code[0];
          sel_act  = q_head.act[0];
        end
        kerm_pkg::PLAN_CNT_BITS'(1): begin
          sel_code = q_head.code[1];
          sel_act  = q_head.act[1];
        end
        default: begin
          sel_code = q_head.code[2];
          sel_act  = q_head.act[2];
        end
      endcase
    end
  end

  // Step through the plan and track the output register.
  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = at_sync ? '0 : idx_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_code    <= sel_code;
      out_action  <= sel_act;
      out_is_sync <= at_sync;
      out_last    <= at_sync;
    end
  end

endmodule

// ----- design/kerm_checker.sv -----
// ----------------------------------------------------------------------------
// kerm_checker: port-level checks for the key event remapper
// Watches the result channel for sync framing, legal actions and reset.
// ----------------------------------------------------------------------------
module kerm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          empty,
  input logic                          pop,
  input logic [kerm_pkg::KEY_BITS-1:0] out_code,
  input logic [1:0]                    out_action,
  input logic                          out_is_sync,
  input logic                          out_last
);

  // The result channel is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) ($past(rst_n) == 1'b0) |-> empty)
    else $error("result channel not empty after reset");

  // Only the sync result closes an event, and it carries zero code and action.
  a_last_is_sync: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_last == out_is_sync))
    else $error("last and sync disagree");

  a_sync_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_is_sync) |-> (out_code == '0 && out_action == kerm_pkg::ACT_RELEASE))
    else $error("sync result carries a key");

  // Emitted actions are release, press or repeat.
  a_action_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_action != kerm_pkg::ACT_REPEAT_ALT))
    else $error("illegal emitted action");

  // A waiting result holds until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_code) && $stable(out_action) &&
                          $stable(out_is_sync)))
    else $error("waiting result changed");

endmodule

bind key_event_remapper kerm_checker u_kerm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .empty       (empty),
  .pop         (pop),
  .out_code    (out_code),
  .out_action  (out_action),
  .out_is_sync (out_is_sync),
  .out_last    (out_last)
);
